/* rtl/hwbp_pkg.sv */
// ----------------------------------------------------------------------------
// hwbp_pkg: shared types and constants of the breakpoint slot table
// Operation, kind and status codes, the slot record and the DR7 code helpers.
// ----------------------------------------------------------------------------
package hwbp_pkg;

	// Slot table size, clamped to the four debug address registers.
	localparam int NUM_SLOTS  = 4;
	localparam int MAX_HW     = 4;
	localparam int TABLE_SIZE = (NUM_SLOTS < 1) ? 1 : ((NUM_SLOTS > MAX_HW) ? MAX_HW : NUM_SLOTS);

	// Field widths.
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 64;
	localparam int LEN_W    = 8;
	localparam int SLEN_W   = 4;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 3;
	localparam int DR7_W    = 32;
	localparam int IDX_W    = 2;

	// Request codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// Slot kinds.
	localparam logic [KIND_W-1:0] KIND_BREAK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_UNSUPPORTED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_EXISTS      = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd5;

	// DR7 layout.
	localparam logic [DR7_W-1:0] DR7_BASE   = 32'h0000_0600;
	localparam logic [1:0]       DR7_GLOBAL = 2'h2;
	localparam logic [1:0]       RW_BREAK   = 2'h0;
	localparam logic [1:0]       RW_WRITE   = 2'h1;
	localparam logic [1:0]       RW_ACCESS  = 2'h3;
	localparam logic [1:0]       LN_ONE     = 2'h0;
	localparam logic [1:0]       LN_TWO     = 2'h1;
	localparam logic [1:0]       LN_FOUR    = 2'h3;
	localparam logic [1:0]       LN_EIGHT   = 2'h2;

	// One breakpoint or watchpoint slot.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SLEN_W-1:0] len;
		logic [KIND_W-1:0] kind;
	} slot_t;

	// DR7 read/write field for a slot kind.
	function automatic logic [1:0] dr7_rw_field(input logic [KIND_W-1:0] k);
		logic [1:0] c;
		case (k)
			KIND_WRITE:  c = RW_WRITE;
			KIND_ACCESS: c = RW_ACCESS;
			default:     c = RW_BREAK;
		endcase
		return c;
	endfunction

	// DR7 length field for a slot length.
	function automatic logic [1:0] dr7_len_field(input logic [SLEN_W-1:0] l);
		logic [1:0] c;
		case (l)
			4'd2:    c = LN_TWO;
			4'd4:    c = LN_FOUR;
			4'd8:    c = LN_EIGHT;
			default: c = LN_ONE;
		endcase
		return c;
	endfunction

endpackage

/* rtl/hw_breakpoint_slot_table.sv */
// ----------------------------------------------------------------------------
// hw_breakpoint_slot_table: hardware breakpoint slot allocator with DR7 builder
// Inserts, removes and clears breakpoint and watchpoint slots and reports the
// resulting debug register image after every request.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (op, addr, len, kind) is taken at a rising edge where start
//   is high and busy is low. Its result is shown for exactly one cycle with
//   done high: status, count, dr7, dr0..dr3 and hw_enable. The receiver cannot
//   stall; the result must be taken in that cycle.
// Timing:
//   Clear, unused codes and rejected inserts need no table search: done rises
//   in the cycle after the request, and a new request may be taken every
//   cycle. Insert and remove search the table with one shared slot comparator,
//   one slot per cycle. An insert searches every used slot and then appends,
//   or stops at a duplicate; a remove that hits slot h then moves the last
//   slot into the hole, and a miss searches every used slot. The block stays
//   busy and takes no new word until done rises.
// Reset:
//   arst_n clears the slot count and the sequencer; the table is then empty
//   and slot contents are not cleared, since only used slots are ever read.
// ----------------------------------------------------------------------------
module hw_breakpoint_slot_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hwbp_pkg::OP_W-1:0]       op,
	input  logic [hwbp_pkg::ADDR_W-1:0]     addr,
	input  logic [hwbp_pkg::LEN_W-1:0]      len,
	input  logic [hwbp_pkg::KIND_W-1:0]     kind,
	output logic                            done,
	output logic [hwbp_pkg::STATUS_W-1:0]   status,
	output logic [hwbp_pkg::COUNT_W-1:0]    count,
	output logic [hwbp_pkg::DR7_W-1:0]      dr7,
	output logic [hwbp_pkg::ADDR_W-1:0]     dr0,
	output logic [hwbp_pkg::ADDR_W-1:0]     dr1,
	output logic [hwbp_pkg::ADDR_W-1:0]     dr2,
	output logic [hwbp_pkg::ADDR_W-1:0]     dr3
	,
	output logic                            hw_enable
);
	import hwbp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE
	} state_t;

	state_t                state_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    idx_q;
	logic [IDX_W-1:0]      hit_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;

	// Latched request word.
	logic [OP_W-1:0]       req_op_q;
	logic [ADDR_W-1:0]     req_addr_q;
	logic [LEN_W-1:0]      req_len_q;
	logic [KIND_W-1:0]     req_kind_q;

	slot_t                 slots_q [MAX_HW];

	logic                  accept;
	logic [LEN_W-1:0]      len_eff;
	logic                  len_ok;
	logic                  aligned;
	slot_t                 cur;
	logic                  match;
	logic                  scan_end;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	slot_t                 wr_data;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Request checks on the incoming word; a code breakpoint always has length 1.
	assign len_eff = (kind == KIND_BREAK) ? LEN_W'(1) : len;
	assign len_ok  = (len == 8'd1) || (len == 8'd2) || (len == 8'd4) || (len == 8'd8);
	assign aligned = ((addr[2:0] & (len[2:0] - 3'd1)) == 3'd0);

	// Shared slot comparator, fed from the scan index.
	assign cur      = slots_q[idx_q[IDX_W-1:0]];
	assign match    = (cur.addr == req_addr_q) && (cur.kind == req_kind_q)
	                  && ({{(LEN_W-SLEN_W){1'b0}}, cur.len} == req_len_q);
	assign scan_end = (idx_q == count_q);

	// Table write: append on a successful insert, fill the hole on a remove.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = count_q[IDX_W-1:0];
		wr_data = '{addr: req_addr_q, len: req_len_q[SLEN_W-1:0], kind: req_kind_q};
		if (state_q == ST_SCAN && scan_end && req_op_q == OP_INSERT) begin
			wr_en = 1'b1;
		end else if (state_q == ST_MOVE) begin
			wr_en   = 1'b1;
			wr_idx  = hit_q;
			wr_data = cur;
		end
	end

	// Slot storage and request capture; no reset needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_idx] <= wr_data;
		end
		if (accept) begin
			req_op_q   <= op;
			req_addr_q <= addr;
			req_len_q  <= len_eff;
			req_kind_q <= kind;
		end
	end

	// Sequencer with slot count and registered result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			hit_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						unique case (op)
							OP_INSERT: begin
								if (kind != KIND_BREAK && kind != KIND_WRITE
								    && kind != KIND_ACCESS) begin
									status_q <= STAT_UNSUPPORTED;
									done_q   <= 1'b1;
								end else if (kind != KIND_BREAK && !(len_ok && aligned)) begin
									status_q <= STAT_INVALID;
									done_q   <= 1'b1;
								end else if (count_q >= COUNT_W'(TABLE_SIZE)) begin
									status_q <= STAT_FULL;
									done_q   <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							OP_REMOVE: begin
								state_q <= ST_SCAN;
							end
							OP_CLEAR: begin
								count_q  <= '0;
								status_q <= STAT_OK;
								done_q   <= 1'b1;
							end
							default: begin
								status_q <= STAT_INVALID;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						// Searched every used slot without a hit.
						if (req_op_q == OP_INSERT) begin
							count_q  <= count_q + COUNT_W'(1);
							status_q <= STAT_OK;
						end else begin
							status_q <= STAT_NOT_FOUND;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (match) begin
						if (req_op_q == OP_INSERT) begin
							status_q <= STAT_EXISTS;
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							hit_q   <= idx_q[IDX_W-1:0];
							idx_q   <= count_q - COUNT_W'(1);
							state_q <= ST_MOVE;
						end
					end else begin
						idx_q <= idx_q + COUNT_W'(1);
					end
				end
				ST_MOVE: begin
					count_q  <= count_q - COUNT_W'(1);
					status_q <= STAT_OK;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Debug register image built from the used slots.
	logic [ADDR_W-1:0] dr_addr [MAX_HW];

	always_comb begin
		dr7 = '0;
		for (int i = 0; i < MAX_HW; i++) begin
			dr_addr[i] = '0;
			if (COUNT_W'(i) < count_q) begin
				dr_addr[i]         = slots_q[i].addr;
				dr7[2*i +: 2]      = DR7_GLOBAL;
				dr7[16 + 4*i +: 2] = dr7_rw_field(slots_q[i].kind);
				dr7[18 + 4*i +: 2] = dr7_len_field(slots_q[i].len);
			end
		end
		if (count_q != '0) begin
			dr7 = dr7 | DR7_BASE;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign count     = count_q;
	assign dr0       = dr_addr[0];
	assign dr1       = dr_addr[1];
	assign dr2       = dr_addr[2];
	assign dr3       = dr_addr[3];
	assign hw_enable = (count_q != '0);

`ifndef SYNTH
	// An accepted word either finishes next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted word neither finished nor kept block busy");

	// The slot count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_SIZE))
		else $error("slot count beyond table size");

	// A successful insert grows the table by exactly one slot.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_end && req_op_q == OP_INSERT)
		|=> (count_q == $past(count_q) + COUNT_W'(1)) && done && status == STAT_OK)
		else $error("insert did not add a slot");

	// The remove move step only runs on a non-empty table.
	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |-> (count_q != '0) && busy && !done)
		else $error("slot move on empty table");
`endif

endmodule
